// File: rtl/pprj_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pprj_pkg;

  // Fixed field widths
  localparam int TRIG_W     = 16;
  localparam int DIST_W     = 12;
  localparam int OUT_W      = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROLL_COS  = 3'd0,
    REG_ROLL_SIN  = 3'd1,
    REG_PITCH_COS = 3'd2,
    REG_PITCH_SIN = 3'd3,
    REG_VIEW_DIST = 3'd4
  } cfg_reg_t;

  // Signed width of the rotated coordinates (2*frac fraction bits)
  function automatic int rot_w(int c, int t);
    int m;
    m = 42;
    if (c + t + 14 > m) m = c + t + 14;
    if (c + 29 > m) m = c + 29;
    return m + 3;
  endfunction

  // Signed width of the depth term
  function automatic int z_w(int c);
    int m;
    m = 27;
    if (c + 14 > m) m = c + 14;
    return m + 2;
  endfunction

  // Width of the dividend after the frac-bit shift
  function automatic int num_w(int c, int t);
    return rot_w(c, t) - 1 + DIST_W - t;
  endfunction

endpackage

`default_nettype wire

// File: rtl/pprj_front.sv
`timescale 1ns / 1ps
`default_nettype none

module pprj_front import pprj_pkg::*; #(
  parameter int TRIG_FRAC_BITS = 14,
  parameter int COORD_BITS     = 12
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  in_valid,
  output logic                                       in_ready,
  input  wire logic signed [COORD_BITS-1:0]          pt_x,
  input  wire logic signed [COORD_BITS-1:0]          pt_y,
  input  wire logic signed [TRIG_W-1:0]              roll_cos,
  input  wire logic signed [TRIG_W-1:0]              roll_sin,
  input  wire logic signed [TRIG_W-1:0]              pitch_cos,
  input  wire logic signed [TRIG_W-1:0]              pitch_sin,
  input  wire logic [DIST_W-1:0]                     view_dist,
  output logic                                       push,
  input  wire logic                                  queue_full,
  output logic [num_w(COORD_BITS, TRIG_FRAC_BITS)-1:0] num_x,
  output logic [num_w(COORD_BITS, TRIG_FRAC_BITS)-1:0] num_y,
  output logic [z_w(COORD_BITS)-2:0]                 depth_mag,
  output logic                                       neg_x,
  output logic                                       neg_y
);

  localparam int C  = COORD_BITS;
  localparam int T  = TRIG_FRAC_BITS;
  localparam int RW = rot_w(C, T);
  localparam int ZW = z_w(C);
  localparam int ZM = ZW - 1;
  localparam int MW = RW - 1;
  localparam int LH = MW / 2;
  localparam int HH = MW - LH;
  localparam int PW = MW + DIST_W;
  localparam int DP = DIST_W + TRIG_W + 1;
  localparam logic signed [ZW-1:0] HALF = ZW'(64'd1 << (T - 1));

  logic en;
  logic v1, v2, v3, v4, v5, v6;
  logic signed [DIST_W:0] dist_s;

  logic signed [C+15:0] xcr1, xsr1, ysr1, ycr1, ysp1;
  logic signed [DP-1:0] dsr1, dcr1, dcp1;

  logic signed [C+15:0]      xcr2, xsr2;
  logic signed [C+31:0]      ysrcp2, ycrcp2;
  logic signed [DP+15:0]     dsrsp2, dcrsp2;
  logic signed [ZW-1:0]      z2;

  logic signed [RW-1:0] rx3, ry3;
  logic signed [ZW-1:0] z3;

  logic [MW-1:0] rxm4, rym4;
  logic [ZM-1:0] zm4, zm5;
  logic          nx4, ny4, nx5, ny5;

  logic [LH+DIST_W-1:0] lox5, loy5;
  logic [HH+DIST_W-1:0] hix5, hiy5;
  logic [PW-1:0]        prod_x, prod_y;

  assign dist_s = signed'({1'b0, view_dist});

  // Advance the whole pipe unless the finished word cannot enter the queue
  assign en       = !(v6 && queue_full);
  assign in_ready = en;
  assign push     = v6 && en;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      v6 <= v5;
    end
  end

  always_comb begin
    prod_x = (PW'(hix5) << LH) + PW'(lox5);
    prod_y = (PW'(hiy5) << LH) + PW'(loy5);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // first products
      xcr1 <= pt_x * roll_cos;
      xsr1 <= pt_x * roll_sin;
      ysr1 <= pt_y * roll_sin;
      ycr1 <= pt_y * roll_cos;
      ysp1 <= pt_y * pitch_sin;
      dsr1 <= dist_s * roll_sin;
      dcr1 <= dist_s * roll_cos;
      dcp1 <= dist_s * pitch_cos;
      // second products and depth
      xcr2   <= xcr1;
      xsr2   <= xsr1;
      ysrcp2 <= ysr1 * pitch_cos;
      ycrcp2 <= ycr1 * pitch_cos;
      dsrsp2 <= dsr1 * pitch_sin;
      dcrsp2 <= dcr1 * pitch_sin;
      z2     <= ZW'(ysp1) + ZW'(dcp1);
      // rotated coordinates, depth held away from zero
      rx3 <= (RW'(xcr2) <<< T) - RW'(ysrcp2) + RW'(dsrsp2);
      ry3 <= (RW'(xsr2) <<< T) + RW'(ycrcp2) - RW'(dcrsp2);
      if (z2 < HALF && z2 > -HALF) begin
        z3 <= z2[ZW-1] ? -HALF : HALF;
      end else begin
        z3 <= z2;
      end
      // magnitudes and quotient signs
      rxm4 <= rx3[RW-1] ? MW'(-rx3) : MW'(rx3);
      rym4 <= ry3[RW-1] ? MW'(-ry3) : MW'(ry3);
      zm4  <= z3[ZW-1] ? ZM'(-z3) : ZM'(z3);
      nx4  <= rx3[RW-1] ^ z3[ZW-1];
      ny4  <= ry3[RW-1] ^ z3[ZW-1];
      // scale by distance in two halves
      lox5 <= rxm4[LH-1:0] * view_dist;
      hix5 <= rxm4[MW-1:LH] * view_dist;
      loy5 <= rym4[LH-1:0] * view_dist;
      hiy5 <= rym4[MW-1:LH] * view_dist;
      zm5  <= zm4;
      nx5  <= nx4;
      ny5  <= ny4;
      // join halves, drop the frac bits the divisor carries
      num_x     <= prod_x[PW-1:T];
      num_y     <= prod_y[PW-1:T];
      depth_mag <= zm5;
      neg_x     <= nx5;
      neg_y     <= ny5;
    end
  end

endmodule

`default_nettype wire

// File: rtl/pprj_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module pprj_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      rd_data,
  output logic                  full,
  output logic                  empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [AW-1:0]    wr_ptr, rd_ptr;
  logic [CW-1:0]    count;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign rd_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/pprj_div_stage.sv
`timescale 1ns / 1ps
`default_nettype none

module pprj_div_stage #(
  parameter int NW = 42,
  parameter int ZM = 29
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          en,
  input  wire logic          in_valid,
  input  wire logic [ZM-1:0] in_rem_x,
  input  wire logic [NW-1:0] in_num_x,
  input  wire logic [ZM-1:0] in_rem_y,
  input  wire logic [NW-1:0] in_num_y,
  input  wire logic [ZM-1:0] in_den,
  input  wire logic          in_neg_x,
  input  wire logic          in_neg_y,
  output logic               out_valid,
  output logic [ZM-1:0]      out_rem_x,
  output logic [NW-1:0]      out_num_x,
  output logic [ZM-1:0]      out_rem_y,
  output logic [NW-1:0]      out_num_y,
  output logic [ZM-1:0]      out_den,
  output logic               out_neg_x,
  output logic               out_neg_y
);

  logic [ZM:0] try_x, try_y;
  logic        ge_x, ge_y;

  // One restoring step: bring down the next dividend bit, subtract if it fits
  always_comb begin
    try_x = {in_rem_x, in_num_x[NW-1]};
    try_y = {in_rem_y, in_num_y[NW-1]};
    ge_x  = (try_x >= {1'b0, in_den});
    ge_y  = (try_y >= {1'b0, in_den});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_rem_x <= ge_x ? ZM'(try_x - {1'b0, in_den}) : ZM'(try_x);
      out_rem_y <= ge_y ? ZM'(try_y - {1'b0, in_den}) : ZM'(try_y);
      out_num_x <= {in_num_x[NW-2:0], ge_x};
      out_num_y <= {in_num_y[NW-2:0], ge_y};
      out_den   <= in_den;
      out_neg_x <= in_neg_x;
      out_neg_y <= in_neg_y;
    end
  end

endmodule

`default_nettype wire

// File: rtl/pprj_back.sv
`timescale 1ns / 1ps
`default_nettype none

module pprj_back import pprj_pkg::*; #(
  parameter int NW = 42,
  parameter int ZM = 29
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          queue_empty,
  output logic               pop,
  input  wire logic [NW-1:0] num_x,
  input  wire logic [NW-1:0] num_y,
  input  wire logic [ZM-1:0] depth_mag,
  input  wire logic          neg_x,
  input  wire logic          neg_y,
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic [OUT_W-1:0]   proj_x,
  output logic [OUT_W-1:0]   proj_y,
  output logic               clipped
);

  logic en;

  logic          st_valid [NW+1];
  logic [ZM-1:0] st_rem_x [NW+1];
  logic [NW-1:0] st_num_x [NW+1];
  logic [ZM-1:0] st_rem_y [NW+1];
  logic [NW-1:0] st_num_y [NW+1];
  logic [ZM-1:0] st_den   [NW+1];
  logic          st_neg_x [NW+1];
  logic          st_neg_y [NW+1];

  logic [NW-1:0]    q_x, q_y;
  logic [OUT_W-1:0] sat_x, sat_y;
  logic             clip_x, clip_y;

  // Hold every stage while the result word waits
  assign en  = !out_valid || out_ready;
  assign pop = en && !queue_empty;

  assign st_valid[0] = !queue_empty;
  assign st_rem_x[0] = '0;
  assign st_rem_y[0] = '0;
  assign st_num_x[0] = num_x;
  assign st_num_y[0] = num_y;
  assign st_den[0]   = depth_mag;
  assign st_neg_x[0] = neg_x;
  assign st_neg_y[0] = neg_y;

  for (genvar s = 0; s < NW; s++) begin : g_step
    pprj_div_stage #(
      .NW (NW),
      .ZM (ZM)
    ) u_stage (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .in_valid  (st_valid[s]),
      .in_rem_x  (st_rem_x[s]),
      .in_num_x  (st_num_x[s]),
      .in_rem_y  (st_rem_y[s]),
      .in_num_y  (st_num_y[s]),
      .in_den    (st_den[s]),
      .in_neg_x  (st_neg_x[s]),
      .in_neg_y  (st_neg_y[s]),
      .out_valid (st_valid[s+1]),
      .out_rem_x (st_rem_x[s+1]),
      .out_num_x (st_num_x[s+1]),
      .out_rem_y (st_rem_y[s+1]),
      .out_num_y (st_num_y[s+1]),
      .out_den   (st_den[s+1]),
      .out_neg_x (st_neg_x[s+1]),
      .out_neg_y (st_neg_y[s+1])
    );
  end

  assign q_x = st_num_x[NW];
  assign q_y = st_num_y[NW];

  // Saturate to int32; an exact -2^31 is no clip
  always_comb begin
    if (st_neg_x[NW]) begin
      clip_x = (|q_x[NW-1:OUT_W]) || (q_x[OUT_W-1] && (|q_x[OUT_W-2:0]));
      sat_x  = clip_x ? {1'b1, {(OUT_W-1){1'b0}}} : -q_x[OUT_W-1:0];
    end else begin
      clip_x = |q_x[NW-1:OUT_W-1];
      sat_x  = clip_x ? {1'b0, {(OUT_W-1){1'b1}}} : q_x[OUT_W-1:0];
    end
    if (st_neg_y[NW]) begin
      clip_y = (|q_y[NW-1:OUT_W]) || (q_y[OUT_W-1] && (|q_y[OUT_W-2:0]));
      sat_y  = clip_y ? {1'b1, {(OUT_W-1){1'b0}}} : -q_y[OUT_W-1:0];
    end else begin
      clip_y = |q_y[NW-1:OUT_W-1];
      sat_y  = clip_y ? {1'b0, {(OUT_W-1){1'b1}}} : q_y[OUT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= st_valid[NW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      proj_x  <= sat_x;
      proj_y  <= sat_y;
      clipped <= clip_x || clip_y;
    end
  end

endmodule

`default_nettype wire

// File: rtl/pitch_roll_perspective_projector.sv
// Quotient: Q = num_w(COORD_BITS, TRIG_FRAC_BITS) bits (42 by default).
// Throughput: one point per cycle while the result stream is not stalled; the quotient is formed
//   by a pipeline of Q restoring divide steps, one bit per stage, for both coordinates in step.
// Reset: synchronous, active high; clears all valid flags and the queue and
//   loads the register defaults (no roll, no pitch, view distance 256).
`timescale 1ns / 1ps
`default_nettype none

module pitch_roll_perspective_projector import pprj_pkg::*; #(
  parameter int TRIG_FRAC_BITS = 14,
  parameter int COORD_BITS     = 12
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  // input stream
  input  wire logic                                 s_axis_tvalid,
  output logic                                      s_axis_tready,
  input  wire logic [((2*COORD_BITS+7)/8)*8-1:0]    s_axis_tdata,  // point_x, point_y
  // result stream
  output logic                                      m_axis_tvalid,
  input  wire logic                                 m_axis_tready,
  output logic [2*OUT_W-1:0]                        m_axis_tdata,  // proj_x, proj_y
  output logic                                      m_axis_tuser,  // clipped
  // register writes
  input  wire logic                                 cfg_valid,
  output logic                                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]                 cfg_index,
  input  wire logic [CFG_DATA_W-1:0]                cfg_data
);

  localparam int C     = COORD_BITS;
  localparam int NW    = num_w(COORD_BITS, TRIG_FRAC_BITS);
  localparam int ZM    = z_w(COORD_BITS) - 1;
  localparam int QW    = 2 * NW + ZM + 2;
  localparam int QDEPTH = 4;

  // Register file; the user must write it only while the block is idle (not enforced here)
  logic signed [TRIG_W-1:0] roll_cos, roll_sin, pitch_cos, pitch_sin;
  logic [DIST_W-1:0]        view_dist;

  // Front to queue
  logic          f_push;
  logic [NW-1:0] f_num_x, f_num_y;
  logic [ZM-1:0] f_depth;
  logic          f_neg_x, f_neg_y;

  // Queue to back
  logic [QW-1:0] q_wr, q_rd;
  logic          q_full, q_empty, q_pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      roll_cos  <= 16'sd16384;
      roll_sin  <= '0;
      pitch_cos <= 16'sd16384;
      pitch_sin <= '0;
      view_dist <= 12'd256;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_ROLL_COS:  roll_cos  <= signed'(cfg_data);
        REG_ROLL_SIN:  roll_sin  <= signed'(cfg_data);
        REG_PITCH_COS: pitch_cos <= signed'(cfg_data);
        REG_PITCH_SIN: pitch_sin <= signed'(cfg_data);
        REG_VIEW_DIST: view_dist <= cfg_data[DIST_W-1:0];
        default: ;  // drop writes to unknown indexes
      endcase
    end
  end

  // Front: rotation, depth guard, distance scaling
  pprj_front #(
    .TRIG_FRAC_BITS (TRIG_FRAC_BITS),
    .COORD_BITS     (COORD_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .pt_x       (signed'(s_axis_tdata[C-1:0])),
    .pt_y       (signed'(s_axis_tdata[2*C-1:C])),
    .roll_cos   (roll_cos),
    .roll_sin   (roll_sin),
    .pitch_cos  (pitch_cos),
    .pitch_sin  (pitch_sin),
    .view_dist  (view_dist),
    .push       (f_push),
    .queue_full (q_full),
    .num_x      (f_num_x),
    .num_y      (f_num_y),
    .depth_mag  (f_depth),
    .neg_x      (f_neg_x),
    .neg_y      (f_neg_y)
  );

  assign q_wr = {f_neg_y, f_neg_x, f_depth, f_num_y, f_num_x};

  // Short queue lets the front run on while the result side stalls
  pprj_queue #(
    .WIDTH (QW),
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (f_push),
    .wr_data (q_wr),
    .pop     (q_pop),
    .rd_data (q_rd),
    .full    (q_full),
    .empty   (q_empty)
  );

  // Back: divide by the depth, truncate, saturate
  pprj_back #(
    .NW (NW),
    .ZM (ZM)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .queue_empty (q_empty),
    .pop         (q_pop),
    .num_x       (q_rd[NW-1:0]),
    .num_y       (q_rd[2*NW-1:NW]),
    .depth_mag   (q_rd[2*NW+ZM-1:2*NW]),
    .neg_x       (q_rd[2*NW+ZM]),
    .neg_y       (q_rd[2*NW+ZM+1]),
    .out_valid   (m_axis_tvalid),
    .out_ready   (m_axis_tready),
    .proj_x      (m_axis_tdata[OUT_W-1:0]),
    .proj_y      (m_axis_tdata[2*OUT_W-1:OUT_W]),
    .clipped     (m_axis_tuser)
  );

endmodule

`default_nettype wire

// File: sim/tb_pitch_roll_perspective_projector.sv
`timescale 1ns / 1ps

module tb_pitch_roll_perspective_projector;
  import pprj_pkg::*;

  localparam int TRIG_FRAC_BITS = 14;
  localparam int COORD_BITS     = 12;
  localparam int LATENCY        = 49;
  // Indexes with no register behind them; the block must ignore them
  localparam logic [CFG_IDX_W-1:0] REG_NONE  = 3'd7;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd5;

  typedef struct packed {
    logic signed [OUT_W-1:0] proj_x;
    logic signed [OUT_W-1:0] proj_y;
    logic                    clipped;
  } proj_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                            s_axis_tvalid = 1'b0;
  logic                            s_axis_tready;
  logic [23:0]                     s_axis_tdata = '0;  // point_x, point_y
  logic                            m_axis_tvalid;
  logic                            m_axis_tready = 1'b0;
  logic [2*OUT_W-1:0]              m_axis_tdata;       // proj_x, proj_y
  logic                            m_axis_tuser;       // clipped
  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  logic [CFG_IDX_W-1:0]            cfg_index = '0;
  logic [CFG_DATA_W-1:0]           cfg_data = '0;

  pitch_roll_perspective_projector #(
    .TRIG_FRAC_BITS(TRIG_FRAC_BITS),
    .COORD_BITS    (COORD_BITS)
  ) u_dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Shadow copy of the register file, updated as each write is accepted
  logic signed [15:0] roll_cos, roll_sin, pitch_cos, pitch_sin;
  logic [11:0]        view_dist;

  logic [23:0] point_queue[$];   // points waiting to be offered
  proj_t       proj_queue[$];    // projections still owed by the block
  int          mismatches = 0;
  int          points_taken = 0;
  bit          calm = 1'b0;      // suppress sender gaps for a stretch

  task automatic report(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d, expected %0d", what, got, want);
    mismatches++;
  endtask

  // Divide truncating toward zero, saturate to int32, flag saturation
  function automatic logic [31:0] scaled_quot(input longint num, input longint den,
                                              inout bit clip);
    longint unsigned an, ad, q;
    bit neg;
    an  = num < 0 ? longint'(-num) : num;
    ad  = den < 0 ? longint'(-den) : den;
    q   = an / ad;
    neg = (num < 0) != (den < 0);
    if (q == 0) return '0;
    if (neg) begin
      if (q > 64'd2147483648) begin
        clip = 1'b1;
        q = 64'd2147483648;
      end
      return 32'(-q);
    end
    if (q > 64'd2147483647) begin
      clip = 1'b1;
      q = 64'd2147483647;
    end
    return 32'(q);
  endfunction

  function automatic proj_t project_point(input logic [23:0] word);
    longint x, y, cr, sr, cp, sp, d, unit, half, rx, ry, z;
    bit clip;
    proj_t p;
    x    = $signed(word[11:0]);
    y    = $signed(word[23:12]);
    cr   = roll_cos;
    sr   = roll_sin;
    cp   = pitch_cos;
    sp   = pitch_sin;
    d    = view_dist;
    unit = 64'sd1 <<< TRIG_FRAC_BITS;
    half = unit / 2;
    clip = 1'b0;
    rx = x * cr * unit - y * sr * cp + d * sr * sp;
    ry = x * sr * unit + y * cr * cp - d * cr * sp;
    z  = y * sp + d * cp;
    // clamp a near-zero depth to a half, zero counting as positive
    if (z < half && z > -half) z = (z < 0) ? -half : half;
    p.proj_x  = scaled_quot(rx * d, z * unit, clip);
    p.proj_y  = scaled_quot(ry * d, z * unit, clip);
    p.clipped = clip;
    return p;
  endfunction

  // Sender: predict each accepted word, then offer the next after a random gap
  int gap = 0;
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      gap = 0;
    end else if (!(s_axis_tvalid && !s_axis_tready)) begin
      if (s_axis_tvalid) begin
        proj_queue.push_back(project_point(s_axis_tdata));
        points_taken++;
      end
      if (gap > 0) begin
        gap--;
        s_axis_tvalid <= 1'b0;
      end else if (point_queue.size() > 0) begin
        s_axis_tdata  <= point_queue.pop_front();
        s_axis_tvalid <= 1'b1;
        if (calm || $urandom_range(0, 9) < 6) gap = 0;
        else if ($urandom_range(0, 9) < 8) gap = $urandom_range(1, 3);
        else gap = $urandom_range(10, 40);
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Receiver back-pressure; one long hold-off once the stream is under way
  int  stall = 0;
  bit  long_hold_done = 1'b0;
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (!long_hold_done && points_taken >= 300) begin
        long_hold_done = 1'b1;
        stall = 400;
      end
      if (stall > 0) begin
        stall--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        if (!calm && $urandom_range(0, 9) < 3)
          stall = ($urandom_range(0, 9) < 9) ? $urandom_range(1, 3) : $urandom_range(10, 50);
      end
    end
  end

  // Monitor: compare each accepted result word with the oldest prediction
  always @(posedge clk) begin
    proj_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (proj_queue.size() == 0) begin
        report("unexpected word, proj_x", $signed(m_axis_tdata[31:0]), 0);
      end else begin
        want = proj_queue.pop_front();
        if (m_axis_tdata[31:0] !== want.proj_x)
          report("proj_x", $signed(m_axis_tdata[31:0]), want.proj_x);
        if (m_axis_tdata[63:32] !== want.proj_y)
          report("proj_y", $signed(m_axis_tdata[63:32]), want.proj_y);
        if (m_axis_tuser !== want.clipped)
          report("clipped", m_axis_tuser, want.clipped);
      end
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_ROLL_COS:  roll_cos  = value;
      REG_ROLL_SIN:  roll_sin  = value;
      REG_PITCH_COS: pitch_cos = value;
      REG_PITCH_SIN: pitch_sin = value;
      REG_VIEW_DIST: view_dist = value[11:0];
      default: ;
    endcase
  endtask

  task automatic load_view(input logic [15:0] cr, input logic [15:0] sr,
                           input logic [15:0] cp, input logic [15:0] sp,
                           input logic [15:0] d);
    write_reg(REG_ROLL_COS, cr);
    write_reg(REG_ROLL_SIN, sr);
    write_reg(REG_PITCH_COS, cp);
    write_reg(REG_PITCH_SIN, sp);
    write_reg(REG_VIEW_DIST, d);
  endtask

  // Hold until every word is out and the pipeline has drained
  task automatic drain();
    do @(posedge clk);
    while (point_queue.size() > 0 || s_axis_tvalid || proj_queue.size() > 0);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  function automatic logic [23:0] pack_point(input logic [11:0] x, input logic [11:0] y);
    return {y, x};
  endfunction

  function automatic logic [15:0] rand_trig();
    case ($urandom_range(0, 5))
      0:       return 16'($urandom_range(0, 65535));
      1:       return 16'sh4000;
      2:       return 16'shC000;
      3:       return 16'h0000;
      default: return 16'($signed($urandom_range(0, 32768)) - 16384);
    endcase
  endfunction

  logic [15:0] sp_pick, cp_pick, d_pick;

  initial begin
    roll_cos  = 16'sd16384;
    roll_sin  = 16'sd0;
    pitch_cos = 16'sd16384;
    pitch_sin = 16'sd0;
    view_dist = 12'd256;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed: field extremes under the reset view
    point_queue.push_back(pack_point(12'h800, 12'h800));
    point_queue.push_back(pack_point(12'h7FF, 12'h7FF));
    point_queue.push_back(pack_point(12'h000, 12'h000));
    point_queue.push_back(pack_point(12'h800, 12'h7FF));
    point_queue.push_back(pack_point(12'h7FF, 12'h800));
    point_queue.push_back(pack_point(12'hFFF, 12'h001));
    drain();

    // Zero depth everywhere: clamp to plus a half
    load_view(16'h4000, 16'h0000, 16'h0000, 16'h0000, 16'd4095);
    point_queue.push_back(pack_point(12'h7FF, 12'h000));
    point_queue.push_back(pack_point(12'h800, 12'h7FF));
    // Small depth near zero: y*sp just below and just above zero
    drain();
    load_view(16'h4000, 16'h2000, 16'h0000, 16'h0001, 16'd4095);
    point_queue.push_back(pack_point(12'h7FF, 12'hFFF));
    point_queue.push_back(pack_point(12'h800, 12'h800));
    point_queue.push_back(pack_point(12'h123, 12'h001));
    drain();

    // Trig at the most negative code, largest distance
    load_view(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'd4095);
    point_queue.push_back(pack_point(12'h800, 12'h800));
    point_queue.push_back(pack_point(12'h7FF, 12'h800));
    point_queue.push_back(pack_point(12'h800, 12'h7FF));
    drain();

    // Trig at the most positive code, zero and unit distance
    load_view(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'd0);
    point_queue.push_back(pack_point(12'h7FF, 12'h7FF));
    point_queue.push_back(pack_point(12'h800, 12'h123));
    drain();
    write_reg(REG_VIEW_DIST, 16'hF001);
    point_queue.push_back(pack_point(12'h7FF, 12'h7FF));
    point_queue.push_back(pack_point(12'h800, 12'h800));
    drain();

    // A write to an unused index must leave the view alone
    write_reg(REG_NONE, 16'h1234);
    write_reg(REG_SPARE, 16'hFFFF);
    point_queue.push_back(pack_point(12'h555, 12'hAAA));
    point_queue.push_back(pack_point(12'hAAA, 12'h555));
    drain();

    // Random phases: new view each time, some with depth steered near zero
    for (int phase = 0; phase < 12; phase++) begin
      cp_pick = rand_trig();
      sp_pick = rand_trig();
      d_pick  = (phase % 4 == 0) ? 16'($urandom_range(0, 4095)) : 16'($urandom_range(1, 600));
      if (phase % 3 == 2) begin
        cp_pick = 16'($urandom_range(0, 3));
        sp_pick = 16'($urandom_range(0, 65535));
      end
      load_view(rand_trig(), rand_trig(), cp_pick, sp_pick, d_pick);
      calm = (phase % 5 == 3);
      for (int k = 0; k < 118; k++)
        point_queue.push_back(24'($urandom_range(0, 24'hFFFFFF)));
      drain();
    end
    calm = 1'b0;

    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
